// ===== rtl/ordered_key_list_table_unit_macros.svh =====
// Assertion macros used by the ordered key list table top level.
`ifndef ORDERED_KEY_LIST_TABLE_UNIT_MACROS_SVH
`define ORDERED_KEY_LIST_TABLE_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define OKL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define OKL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/okl_pkg.sv =====
// Types and codes for the ordered key list table.
package okl_pkg;

	localparam int KEY_W = 32;

	typedef logic [KEY_W-1:0] key_t;

	// Request commands
	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_FIND   = 2'd1,
		CMD_REMOVE = 2'd2
	} cmd_t;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_NOT_FOUND = 2'd1,
		STAT_FULL      = 2'd2
	} stat_t;

	// Control states
	typedef enum logic {
		STATE_IDLE = 1'b0,
		STATE_EXEC = 1'b1
	} state_t;

endpackage

// ===== rtl/ordered_key_list_table_unit.sv =====
// Top level of the ordered key list table: a chain of key cells with a shared controller.
//
// Ordered list of up to DEPTH 32-bit keys with append, find and remove-first-match.
// For each request, in the accept cycle every cell compares its key
// with the request key and registers a match bit; in the execute state the lowest
// matching cell is picked with one DEPTH-bit subtract, the result is loaded into
// the output register, and on remove every cell at or above the match takes its
// right neighbor's key in the same edge. A new request is taken once the previous
// one has left the execute cycle; that cycle waits only while an earlier result is
// still held in the output register. No clearing pass is needed after reset.
`include "ordered_key_list_table_unit_macros.svh"

module ordered_key_list_table_unit
	import okl_pkg::*;
#(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [1:0]               cmd,
	input  logic signed [KEY_W-1:0]  key,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [1:0]               status,
	output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] position,
	output logic [$clog2(DEPTH+1)-1:0] entry_count
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	state_t         state_q, state_d;
	cmd_t           cmd_q;
	key_t           key_q;
	logic [CW-1:0]  count_q, count_d;
	stat_t          status_q, status_d;
	logic [PW-1:0]  position_q, position_d;
	logic           out_valid_q;

	logic           accept;
	logic           do_exec;
	logic           full;
	logic           found;
	logic [DEPTH-1:0] match_vec;
	logic [DEPTH-1:0] match_dec;
	logic [DEPTH-1:0] first_hot;
	logic [DEPTH-1:0] tail_mask;
	logic [DEPTH-1:0] load_vec;
	logic [DEPTH-1:0] shift_vec;
	logic [DEPTH-1:0] use_vec;
	logic [PW-1:0]  first_pos;
	key_t           entry_w [DEPTH];

	assign accept  = in_valid && in_ready;
	assign do_exec = (state_q == STATE_EXEC) && (!out_valid_q || out_ready);
	assign full    = (count_q == CW'(DEPTH));

	// Cell row; each cell hands its key to the left neighbor on a remove
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		key_t nxt;
		if (i == DEPTH - 1) begin : g_last
			assign nxt = entry_w[i];
		end else begin : g_mid
			assign nxt = entry_w[i+1];
		end

		assign use_vec[i]   = (CW'(i) < count_q);
		assign load_vec[i]  = do_exec && (cmd_q == CMD_APPEND) && !full
			&& (count_q == CW'(i));
		assign shift_vec[i] = do_exec && (cmd_q == CMD_REMOVE) && tail_mask[i];

		okl_cell u_cell (
			.clk      (clk),
			.cmp_en   (accept),
			.in_use   (use_vec[i]),
			.cmp_key  (key),
			.load_en  (load_vec[i]),
			.load_key (key_q),
			.shift_en (shift_vec[i]),
			.next_key (nxt),
			.entry    (entry_w[i]),
			.match    (match_vec[i])
		);
	end

	// Lowest match: one-hot pick and the mask of cells at or above it
	assign match_dec = match_vec - DEPTH'(1);
	assign first_hot = match_vec & ~match_dec;
	assign tail_mask = ~(match_vec ^ match_dec) | first_hot;
	assign found     = |match_vec;

	// One-hot to index
	always_comb begin
		first_pos = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (first_hot[i]) begin
				first_pos = first_pos | PW'(i);
			end
		end
	end

	// Result and next count
	always_comb begin
		status_d   = STAT_OK;
		position_d = '0;
		count_d    = count_q;
		case (cmd_q)
			CMD_APPEND: begin
				if (full) begin
					status_d = STAT_FULL;
				end else begin
					position_d = count_q[PW-1:0];
					count_d    = count_q + CW'(1);
				end
			end
			CMD_FIND: begin
				if (found) begin
					position_d = first_pos;
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
			CMD_REMOVE: begin
				if (found) begin
					position_d = first_pos;
					count_d    = count_q - CW'(1);
				end else begin
					status_d = STAT_NOT_FOUND;
				end
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// Controller state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and request handshake
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			STATE_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = STATE_EXEC;
				end
			end
			STATE_EXEC: begin
				if (do_exec) begin
					state_d = STATE_IDLE;
				end
			end
			default: begin
				state_d = STATE_IDLE;
			end
		endcase
	end

	// Captured command and key; the key is held for the append load
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_t'(cmd);
			key_q <= key;
		end
	end

	// Entry count and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (do_exec) begin
				count_q     <= count_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Output payload register
	always_ff @(posedge clk) begin
		if (do_exec) begin
			status_q   <= status_d;
			position_q <= position_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign position    = position_q;
	assign entry_count = count_q;

	// Checks
	`OKL_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(DEPTH), "entry count above depth")
	`OKL_ASSERT_NEXT(a_accept_exec, accept, state_q == STATE_EXEC, "accept did not start execute")
	`OKL_ASSERT_NOW(a_result_src, $rose(out_valid_q), $past(state_q) == STATE_EXEC,
		"result appeared without an execute cycle")
	`OKL_ASSERT_NOW(a_pos_zero, out_valid_q && (status_q != STAT_OK), position_q == '0,
		"nonzero position on failed request")

endmodule

// ===== rtl/okl_cell.sv =====
// One list cell: holds a key, compares it, and takes its right neighbor's key on a shift.
module okl_cell
	import okl_pkg::*;
(
	input  logic clk,
	input  logic cmp_en,
	input  logic in_use,
	input  key_t cmp_key,
	input  logic load_en,
	input  key_t load_key,
	input  logic shift_en,
	input  key_t next_key,
	output key_t entry,
	output logic match
);

	key_t entry_q;
	logic match_s1;

	// Compare against the incoming key; flag only occupied cells
	always_ff @(posedge clk) begin
		if (cmp_en) begin
			match_s1 <= in_use && (entry_q == cmp_key);
		end
	end

	// Close a gap from the right, or take an appended key
	always_ff @(posedge clk) begin
		if (shift_en) begin
			entry_q <= next_key;
		end else if (load_en) begin
			entry_q <= load_key;
		end
	end

	assign entry = entry_q;
	assign match = match_s1;

endmodule

// ===== bench/tb_ordered_key_list_table_unit.sv =====
// Self-checking bench for the ordered key list table: directed cases and random append/find/remove traffic.
module tb_ordered_key_list_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import okl_pkg::*;

	localparam int DEPTH = 64;
	localparam int POS_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Command code outside the defined set; the block must answer it without change
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	// Traffic shapes for the random part
	localparam int MODE_FILL  = 0;
	localparam int MODE_DRAIN = 1;
	localparam int MODE_MIX   = 2;

	localparam int POOL_N       = 24;
	localparam int PHASE_ITEMS  = 475;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 250000;

	typedef struct {
		stat_t            status;
		logic [POS_W-1:0] position;
		logic [CNT_W-1:0] count;
	} list_result_t;

	// Mirror of the key list plus the queue of results still owed by the block
	class key_list_tracker;
		key_t         held_keys[$];
		list_result_t awaited[$];
		int           errors;

		function new();
			errors = 0;
		endfunction

		// Apply one accepted request to the mirror and queue its result
		function void note_request(logic [1:0] op, key_t k);
			list_result_t r;
			int           hit;
			r.status   = STAT_OK;
			r.position = '0;
			hit        = -1;
			if (op == CMD_APPEND) begin
				if (held_keys.size() >= DEPTH) begin
					r.status = STAT_FULL;
				end else begin
					r.position = POS_W'(held_keys.size());
					held_keys.push_back(k);
				end
			end else if (op == CMD_FIND || op == CMD_REMOVE) begin
				for (int i = 0; i < held_keys.size(); i++)
					if (hit < 0 && held_keys[i] == k)
						hit = i;
				if (hit < 0) begin
					r.status = STAT_NOT_FOUND;
				end else begin
					r.position = POS_W'(hit);
					if (op == CMD_REMOVE)
						held_keys.delete(hit);
				end
			end
			r.count = CNT_W'(held_keys.size());
			awaited.push_back(r);
		endfunction

		// Compare one delivered result with the oldest one owed
		function void check_result(logic [1:0] st, logic [POS_W-1:0] pos,
				logic [CNT_W-1:0] cnt);
			list_result_t r;
			if (awaited.size() == 0) begin
				$error("result with nothing pending: status %0d position %0d count %0d",
					st, pos, cnt);
				errors++;
				return;
			end
			r = awaited.pop_front();
			if (st !== r.status) begin
				$error("status: expected %0d, got %0d", r.status, st);
				errors++;
			end
			if (pos !== r.position) begin
				$error("position: expected %0d, got %0d", r.position, pos);
				errors++;
			end
			if (cnt !== r.count) begin
				$error("entry_count: expected %0d, got %0d", r.count, cnt);
				errors++;
			end
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n;
	logic             in_valid;
	logic             in_ready;
	logic [1:0]       cmd;
	key_t             key;
	logic             out_valid;
	logic             out_ready;
	logic [1:0]       status;
	logic [POS_W-1:0] position;
	logic [CNT_W-1:0] entry_count;

	key_list_tracker tracker = new();
	key_t            key_pool[POOL_N];
	int              send_idle_pct = 0;
	int              stall_pct = 0;
	bit              hold_armed = 1'b0;
	int              cycle_count = 0;

	ordered_key_list_table_unit #(.DEPTH(DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.position   (position),
		.entry_count(entry_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Watch both channels; values read here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				tracker.note_request(cmd, key);
			if (out_valid && out_ready)
				tracker.check_result(status, position, entry_count);
		end
	end

	// Result side: random stalls, plus one long hold-off once armed
	initial begin : result_sink
		int held;
		held = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_armed && held < HOLD_CYCLES) begin
				out_ready <= 1'b0;
				held++;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	// Offer one request and hold it until taken, then maybe go idle a while
	task automatic send_request(input logic [1:0] op, input key_t k);
		in_valid <= 1'b1;
		cmd      <= op;
		key      <= k;
		do @(posedge clk); while (!in_ready);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	// Random traffic in runs that fill, drain or mix, keys mostly from a shared pool
	task automatic run_random(input int n);
		int         mode;
		int         left_in_mode;
		int         roll;
		logic [1:0] op;
		key_t       k;
		mode         = MODE_MIX;
		left_in_mode = 0;
		for (int i = 0; i < n; i++) begin
			if (left_in_mode == 0) begin
				mode         = $urandom_range(MODE_MIX, MODE_FILL);
				left_in_mode = $urandom_range(160, 40);
			end
			left_in_mode--;
			roll = $urandom_range(99);
			case (mode)
				MODE_FILL: begin
					op = (roll < 85) ? CMD_APPEND : (roll < 93) ? CMD_FIND :
						(roll < 99) ? CMD_REMOVE : CMD_UNKNOWN;
				end
				MODE_DRAIN: begin
					op = (roll < 12) ? CMD_APPEND : (roll < 25) ? CMD_FIND :
						(roll < 99) ? CMD_REMOVE : CMD_UNKNOWN;
				end
				default: begin
					op = (roll < 38) ? CMD_APPEND : (roll < 64) ? CMD_FIND :
						(roll < 98) ? CMD_REMOVE : CMD_UNKNOWN;
				end
			endcase
			if ($urandom_range(99) < 82)
				k = key_pool[$urandom_range(POOL_N - 1)];
			else
				k = key_t'($urandom);
			send_request(op, k);
		end
	endtask

	initial begin : stimulus
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		cmd      <= CMD_APPEND;
		key      <= '0;

		// Pool holds the key extremes and random values
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < POOL_N; i++)
			key_pool[i] = key_t'($urandom);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty list, key extremes, duplicates, head/middle/tail removal
		send_request(CMD_FIND, 32'h0000_0005);
		send_request(CMD_REMOVE, 32'h0000_0005);
		send_request(CMD_UNKNOWN, 32'h0000_0000);
		send_request(CMD_APPEND, 32'h8000_0000);
		send_request(CMD_APPEND, 32'h7fff_ffff);
		send_request(CMD_APPEND, 32'h0000_0000);
		send_request(CMD_APPEND, 32'hffff_ffff);
		send_request(CMD_APPEND, 32'h7fff_ffff);
		send_request(CMD_APPEND, 32'h5555_5555);
		send_request(CMD_APPEND, 32'haaaa_aaaa);
		send_request(CMD_FIND, 32'h7fff_ffff);
		send_request(CMD_FIND, 32'haaaa_aaaa);
		send_request(CMD_FIND, 32'h8000_0000);
		send_request(CMD_FIND, 32'h0000_0001);
		send_request(CMD_REMOVE, 32'h7fff_ffff);
		send_request(CMD_FIND, 32'h7fff_ffff);
		send_request(CMD_REMOVE, 32'h8000_0000);
		send_request(CMD_REMOVE, 32'haaaa_aaaa);
		send_request(CMD_UNKNOWN, 32'hffff_ffff);
		send_request(CMD_REMOVE, 32'h0000_0000);
		send_request(CMD_REMOVE, 32'h0000_0001);

		// No idling; the sink holds off early so the input side backs up
		hold_armed = 1'b1;
		run_random(PHASE_ITEMS);

		send_idle_pct = 55;
		stall_pct     = 0;
		run_random(PHASE_ITEMS);

		send_idle_pct = 0;
		stall_pct     = 55;
		run_random(PHASE_ITEMS);

		send_idle_pct = 21;
		stall_pct     = 21;
		run_random(PHASE_ITEMS);

		// Let the last results come out
		in_valid <= 1'b0;
		while (tracker.awaited.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/okl_pkg.sv
rtl/okl_cell.sv
rtl/ordered_key_list_table_unit.sv
bench/tb_ordered_key_list_table_unit.sv
